/* design/mrc_pkg.sv */
// ----------------------------------------------------------------------------
// mrc_pkg
// shared types and constants of the mixed-radix index converter
// ----------------------------------------------------------------------------
package mrc_pkg;

	localparam int FIELD_W    = 16;   // width of one index or size field
	localparam int SLOTS      = 4;    // index fields on the ports
	localparam int WIDE_W     = 64;   // offset and element count width
	localparam int COUNT_W    = 3;    // dim_count register width
	localparam int CFG_IDX_W  = 3;    // configuration register index width
	localparam int IN_DATA_W  = SLOTS * FIELD_W + WIDE_W;
	localparam int OUT_DATA_W = WIDE_W + SLOTS * FIELD_W + WIDE_W;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_DIM_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_0 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_1 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_2 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZE_3 = 3'd4;

	// conversion kinds
	localparam logic KIND_TO_OFFSET  = 1'b0;
	localparam logic KIND_TO_INDICES = 1'b1;

	typedef logic [SLOTS-1:0][FIELD_W-1:0] idx_vec_t;

	// one word in flight along the chain
	typedef struct packed {
		logic              kind;
		logic [WIDE_W-1:0] offset;  // horner accumulator
		logic [WIDE_W-1:0] work;    // dividend bits out, quotient bits in
		logic [FIELD_W-1:0] rem;    // partial remainder
		idx_vec_t          idx;     // input indices, then recovered indices
		logic              zflag;   // a zero size was passed
	} item_t;

endpackage

/* design/mixed_radix_index_converter.sv */
// ----------------------------------------------------------------------------
// mixed_radix_index_converter
// index tuple <-> flat offset conversion, dimension 0 varies fastest
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake            | payload
//  ---------+-----------+----------------------+---------------------------------
//  s_       | in        | s_tvalid / s_tready  | tuser: kind; tdata: index_in_0..3,
//           |           |                      | offset_in
//  m_       | out       | m_tvalid / m_tready  | tdata: offset_out, index_out_0..3,
//           |           |                      | total_elements
//  cfg_     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  one word per cycle while the skid slot is empty; an accepted word passes the entry
//  stage, the horner stages and the row of bit-serial divide cells (64 per dimension),
//  then the output register
//  reset clears all valid bits and loads dim_count = 1 and all sizes = 1
//  the whole row moves while the output skid slot is empty; a stall on m_tready
//  first fills the skid slot, then freezes the row and drops s_tready
//  cfg_ready is always high; total_elements settles through the registered product chain after a write
//
module mixed_radix_index_converter #(
	parameter int MAX_DIMS  = 4,
	parameter int DIM_WIDTH = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// input stream
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic                              s_tuser,   // kind
	input  logic [mrc_pkg::IN_DATA_W-1:0]     s_tdata,   // index_in_0..3, offset_in
	// output stream
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [mrc_pkg::OUT_DATA_W-1:0]    m_tdata,   // offset_out, index_out_0..3,
	                                                     // total_elements
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mrc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [mrc_pkg::FIELD_W-1:0]       cfg_data
);
	import mrc_pkg::*;

	localparam int NCELL = MAX_DIMS * WIDE_W;
	localparam int NST   = MAX_DIMS + NCELL;   // entry, horner steps, divide cells
	localparam logic [FIELD_W-1:0] DIM_MASK = FIELD_W'((32'd1 << DIM_WIDTH) - 32'd1);

	// configuration registers
	logic [COUNT_W-1:0] dim_count_q;
	idx_vec_t           size_q;
	logic [COUNT_W-1:0] dims_used;
	logic [SLOTS-1:0]   used;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_count_q <= COUNT_W'(1);
			for (int d = 0; d < SLOTS; d++) size_q[d] <= FIELD_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DIM_COUNT:  dim_count_q <= cfg_data[COUNT_W-1:0];
				REG_DIM_SIZE_0: size_q[0] <= cfg_data & DIM_MASK;
				REG_DIM_SIZE_1: size_q[1] <= cfg_data & DIM_MASK;
				REG_DIM_SIZE_2: size_q[2] <= cfg_data & DIM_MASK;
				REG_DIM_SIZE_3: size_q[3] <= cfg_data & DIM_MASK;
				default: ;
			endcase
		end
	end

	// counts above MAX_DIMS clamp
	assign dims_used = (dim_count_q > COUNT_W'(MAX_DIMS)) ? COUNT_W'(MAX_DIMS) : dim_count_q;

	for (genvar d = 0; d < SLOTS; d++) begin : g_used
		assign used[d] = (COUNT_W'(d) < dims_used);
	end

	// element count: registered product chain over the sizes in use
	logic [WIDE_W-1:0] tot_q [MAX_DIMS];

	always_ff @(posedge clk) begin
		tot_q[0] <= used[0] ? WIDE_W'(size_q[0]) : WIDE_W'(1);
		for (int d = 1; d < MAX_DIMS; d++) begin
			tot_q[d] <= tot_q[d-1] * (used[d] ? WIDE_W'(size_q[d]) : WIDE_W'(1));
		end
	end

	// pipeline enable: the row moves while the skid slot is free
	logic  en;
	logic  skid_valid_q;
	assign en       = !skid_valid_q;
	assign s_tready = en;

	logic  st_valid [NST];
	item_t st_item  [NST];
	item_t ent;

	// entry: unused indices read as zero, horner starts at the top dimension
	always_comb begin
		ent        = '0;
		ent.kind   = s_tuser;
		ent.work   = s_tdata[SLOTS*FIELD_W +: WIDE_W];
		for (int d = 0; d < SLOTS; d++) begin
			ent.idx[d] = used[d] ? (s_tdata[d*FIELD_W +: FIELD_W] & DIM_MASK) : '0;
		end
		ent.offset = WIDE_W'(ent.idx[MAX_DIMS-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_valid[0] <= 1'b0;
		end else if (en) begin
			st_valid[0] <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			st_item[0] <= ent;
		end
	end

	// horner steps, from the dimension below the top down to dimension 0
	for (genvar k = 1; k < MAX_DIMS; k++) begin : g_mac
		mrc_mac #(
			.DIM(MAX_DIMS - 1 - k)
		) u_mac (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (st_valid[k-1]),
			.item_in  (st_item[k-1]),
			.size     (size_q[MAX_DIMS-1-k]),
			.valid_q  (st_valid[k]),
			.item_q   (st_item[k])
		);
	end

	// divide cells, one quotient bit each, dimension 0 first
	for (genvar c = 0; c < NCELL; c++) begin : g_cell
		mrc_cell #(
			.DIM       (c / WIDE_W),
			.LAST      ((c % WIDE_W) == (WIDE_W - 1)),
			.DIM_WIDTH (DIM_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.valid_in (st_valid[MAX_DIMS-1+c]),
			.item_in  (st_item[MAX_DIMS-1+c]),
			.size     (size_q[c / WIDE_W]),
			.active   (used[c / WIDE_W]),
			.valid_q  (st_valid[MAX_DIMS+c]),
			.item_q   (st_item[MAX_DIMS+c])
		);
	end

	// result word from the end of the row
	item_t                 last;
	logic [OUT_DATA_W-1:0] new_word;
	idx_vec_t              idx_res;
	logic [WIDE_W-1:0]     off_res;

	assign last    = st_item[NST-1];
	assign off_res = (last.kind == KIND_TO_INDICES) ? '0 : last.offset;
	assign idx_res = (last.kind == KIND_TO_INDICES) ? last.idx : '0;
	assign new_word = {tot_q[MAX_DIMS-1], idx_res, off_res};

	// output register plus skid slot
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_q;
	logic [OUT_DATA_W-1:0] skid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (m_tready) begin
				skid_valid_q <= 1'b0;
			end
		end else if (out_valid_q && !m_tready) begin
			if (st_valid[NST-1]) begin
				skid_valid_q <= 1'b1;
			end
		end else begin
			out_valid_q <= st_valid[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (m_tready) begin
				out_q <= skid_q;
			end
		end else if (out_valid_q && !m_tready) begin
			skid_q <= new_word;
		end else begin
			out_q <= new_word;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

endmodule

/* design/mrc_mac.sv */
// ----------------------------------------------------------------------------
// mrc_mac
// one horner step: offset = index + size * offset
// ----------------------------------------------------------------------------
module mrc_mac #(
	parameter int DIM = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  mrc_pkg::item_t                item_in,
	input  logic [mrc_pkg::FIELD_W-1:0]   size,
	output logic                          valid_q,
	output mrc_pkg::item_t                item_q
);
	import mrc_pkg::*;

	logic [WIDE_W-1:0] prod;
	item_t             nxt;

	assign prod = item_in.offset * WIDE_W'(size);

	always_comb begin
		nxt        = item_in;
		nxt.offset = prod + WIDE_W'(item_in.idx[DIM]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

endmodule

/* design/mrc_cell.sv */
// ----------------------------------------------------------------------------
// mrc_cell
// one restoring division step; the last cell of a dimension emits the index
// ----------------------------------------------------------------------------
module mrc_cell #(
	parameter int DIM       = 0,
	parameter bit LAST      = 1'b0,
	parameter int DIM_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid_in,
	input  mrc_pkg::item_t                item_in,
	input  logic [mrc_pkg::FIELD_W-1:0]   size,
	input  logic                          active,
	output logic                          valid_q,
	output mrc_pkg::item_t                item_q
);
	import mrc_pkg::*;

	logic [DIM_WIDTH:0]   trial;
	logic [DIM_WIDTH:0]   divisor;
	logic [DIM_WIDTH:0]   diff;
	logic                 qbit;
	logic [DIM_WIDTH-1:0] rem_new;
	item_t                nxt;

	assign divisor = {1'b0, size[DIM_WIDTH-1:0]};
	assign trial   = {item_in.rem[DIM_WIDTH-1:0], item_in.work[WIDE_W-1]};
	assign diff    = trial - divisor;
	assign qbit    = (trial >= divisor);
	assign rem_new = qbit ? diff[DIM_WIDTH-1:0] : trial[DIM_WIDTH-1:0];

	always_comb begin
		nxt      = item_in;
		nxt.work = {item_in.work[WIDE_W-2:0], qbit};
		nxt.rem  = FIELD_W'(rem_new);
		if (LAST) begin
			// remainder is this dimension's index, quotient feeds the next one
			nxt.rem      = '0;
			nxt.idx[DIM] = (active && !item_in.zflag && size != '0) ?
			               FIELD_W'(rem_new) : '0;
			nxt.zflag    = item_in.zflag | (active && size == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			item_q <= nxt;
		end
	end

endmodule
